FILE: rtl/tsepoch_pkg.sv
// ----------------------------------------------------------------------------
// tsepoch_pkg
// Types, constants and calendar tables shared by the timestamp-to-epoch block.
// ----------------------------------------------------------------------------
package tsepoch_pkg;

  // Text parsing
  localparam int unsigned NumFields       = 7;
  localparam int unsigned MaxDigits       = 4;
  localparam int unsigned FieldW          = 14;
  localparam int unsigned FieldIdxW       = 3;
  localparam int unsigned DigitCntW       = 3;
  localparam int unsigned CharW           = 8;
  localparam int unsigned DefaultMaxChars = 23;

  // Field positions
  localparam int unsigned FldYear   = 0;
  localparam int unsigned FldMonth  = 1;
  localparam int unsigned FldDay    = 2;
  localparam int unsigned FldHour   = 3;
  localparam int unsigned FldMinute = 4;
  localparam int unsigned FldSecond = 5;
  localparam int unsigned FldMilli  = 6;

  // Date arithmetic
  localparam int unsigned EpochW      = 53;
  localparam int unsigned DaysW       = 24;
  localparam int unsigned MulConstW   = 27;
  localparam int unsigned YearBias    = 400;      // keeps the shifted year positive
  localparam int unsigned DaysPerYear = 365;
  // 719468 days to the epoch plus one 400-year cycle (146097) for the bias
  localparam int unsigned DaysOffset  = 865565;
  // floor(q / 25) == (q * 1311) >> 15 for every q below 2600
  localparam int unsigned Recip25      = 1311;
  localparam int unsigned Recip25Shift = 15;
  localparam int unsigned Cent100W     = 8;

  localparam logic [MulConstW-1:0] MsPerDay  = MulConstW'(86400000);
  localparam logic [MulConstW-1:0] MsPerHour = MulConstW'(3600000);
  localparam logic [MulConstW-1:0] MsPerMin  = MulConstW'(60000);
  localparam logic [MulConstW-1:0] MsPerSec  = MulConstW'(1000);

  // Multiply-accumulate term selection
  typedef enum logic [1:0] {
    TERM_DAYS = 2'd0,
    TERM_HOUR = 2'd1,
    TERM_MIN  = 2'd2,
    TERM_SEC  = 2'd3
  } term_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic  parse;     // a character beat is taken
    logic  prep;      // shifted year and day-of-year
    logic  div;       // century count
    logic  days;      // day number, accumulator seeded with milliseconds
    logic  mac;       // one multiply-accumulate term
    term_e term;      // which term
    logic  load_out;  // result into output register, parse state cleared
  } cmd_t;

  // Days before the first of a month, with the year starting in March
  function automatic logic [8:0] days_before_month(input logic [3:0] month);
    logic [8:0] d;
    unique case (month)
      4'd3:    d = 9'd0;
      4'd4:    d = 9'd31;
      4'd5:    d = 9'd61;
      4'd6:    d = 9'd92;
      4'd7:    d = 9'd122;
      4'd8:    d = 9'd153;
      4'd9:    d = 9'd184;
      4'd10:   d = 9'd214;
      4'd11:   d = 9'd245;
      4'd12:   d = 9'd275;
      4'd1:    d = 9'd306;
      4'd2:    d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

FILE: rtl/tsepoch_ctrl.sv
// ----------------------------------------------------------------------------
// tsepoch_ctrl
// Controller: takes character beats, then steps the datapath through the
// date arithmetic and hands the result to the output register.
// ----------------------------------------------------------------------------
module tsepoch_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_last_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tsepoch_pkg::cmd_t  cmd_o
);
  import tsepoch_pkg::*;

  typedef enum logic [2:0] {
    ST_PARSE,
    ST_PREP,
    ST_DIV,
    ST_DAYS,
    ST_MAC,
    ST_DONE
  } state_e;

  state_e      state_q;
  logic [1:0]  term_q;
  logic        out_valid_q;

  // Command decode
  always_comb begin
    cmd_o          = '0;
    cmd_o.parse    = in_valid_i && (state_q == ST_PARSE);
    cmd_o.prep     = (state_q == ST_PREP);
    cmd_o.div      = (state_q == ST_DIV);
    cmd_o.days     = (state_q == ST_DAYS);
    cmd_o.mac      = (state_q == ST_MAC);
    cmd_o.term     = term_e'(term_q);
    cmd_o.load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  end

  assign in_ready_o  = (state_q == ST_PARSE);
  assign out_valid_o = out_valid_q;

  // State and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_PARSE;
      term_q      <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      // Result valid: set when the output register loads, cleared once taken
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_PARSE: begin
          if (in_valid_i && in_last_i) begin
            state_q <= ST_PREP;
          end
        end
        ST_PREP: state_q <= ST_DIV;
        ST_DIV:  state_q <= ST_DAYS;
        ST_DAYS: begin
          term_q  <= 2'd0;
          state_q <= ST_MAC;
        end
        ST_MAC: begin
          term_q <= term_q + 2'd1;
          if (term_q == 2'd3) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            state_q <= ST_PARSE;
          end
        end
        default: state_q <= ST_PARSE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // A final character stops the input until the result has been built
  a_last_stops_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.parse && in_last_i) |=> !in_ready_o)
    else $error("input still ready after final character");

  // A new result only appears from the completion state
  a_valid_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result valid raised outside completion");

  // A waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !cmd_o.load_out)
    else $error("output register loaded over a waiting result");
`endif

endmodule

FILE: rtl/tsepoch_dpath.sv
// ----------------------------------------------------------------------------
// tsepoch_dpath
// Datapath: field parser, day-number arithmetic and a shared
// multiply-accumulate unit building the millisecond count.
// ----------------------------------------------------------------------------
module tsepoch_dpath #(
  parameter int unsigned MaxChars = tsepoch_pkg::DefaultMaxChars
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tsepoch_pkg::cmd_t               cmd_i,
  input  logic [tsepoch_pkg::CharW-1:0]   char_i,
  input  logic                            last_i,
  output logic [tsepoch_pkg::EpochW-1:0]  epoch_o,
  output logic                            err_o
);
  import tsepoch_pkg::*;

  localparam int unsigned CntW = $clog2(MaxChars + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxChars);
  localparam int unsigned MulAW = DaysW + 1;
  localparam int unsigned MulBW = MulConstW + 1;
  localparam int unsigned ProdW = MulAW + MulBW;
  localparam int unsigned QuartW = FieldW - 2;
  localparam int unsigned RecipPW = QuartW + 11;

  // Parse state
  logic [FieldIdxW-1:0] fi_q;
  logic [CntW-1:0]      cc_q;
  logic [FieldW-1:0]    acc_q;
  logic [DigitCntW-1:0] dc_q;
  logic                 err_q;
  logic [FieldW-1:0]    fv_q [NumFields];
  logic [FieldW-1:0]    fv_d [NumFields];

  // Arithmetic registers
  logic [FieldW-1:0]    y_q;
  logic [DaysW-1:0]     doy_q;
  logic [Cent100W-1:0]  c100_q;
  logic [DaysW-1:0]     days_q;
  logic [EpochW-1:0]    sum_q;
  logic [EpochW-1:0]    out_epoch_q;
  logic                 out_err_q;

  // Per-character update
  logic                 is_digit, take, fi_open, close1, fi1_open;
  logic [FieldW-1:0]    acc1;
  logic [DigitCntW-1:0] dc1;
  logic [FieldIdxW-1:0] fi1, fi2;
  logic                 err1;

  always_comb begin
    is_digit = (char_i >= 8'h30) && (char_i <= 8'h39);
    take     = (cc_q < MaxCnt);
    fi_open  = (fi_q < FieldIdxW'(NumFields));
    acc1     = acc_q;
    dc1      = dc_q;
    fi1      = fi_q;
    err1     = err_q;
    close1   = 1'b0;
    if (take) begin
      if (is_digit) begin
        if (fi_open) begin
          if (dc_q >= DigitCntW'(MaxDigits)) begin
            err1 = 1'b1;
          end else begin
            acc1 = FieldW'(acc_q * FieldW'(10)) + FieldW'(char_i[3:0]);
            dc1  = dc_q + DigitCntW'(1);
          end
        end
      end else begin
        close1 = 1'b1;
        acc1   = '0;
        dc1    = '0;
        if (fi_open) begin
          fi1 = fi_q + FieldIdxW'(1);
        end
      end
    end
    fi1_open = (fi1 < FieldIdxW'(NumFields));
    fi2      = (last_i && fi1_open) ? fi1 + FieldIdxW'(1) : fi1;
    // Closing on a separator, then once more at the end of the text
    for (int k = 0; k < NumFields; k++) begin
      fv_d[k] = fv_q[k];
      if (close1 && fi_open && (fi_q == FieldIdxW'(k))) begin
        fv_d[k] = acc_q;
      end
      if (last_i && fi1_open && (fi1 == FieldIdxW'(k))) begin
        fv_d[k] = acc1;
      end
    end
  end

  // Parse registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fi_q  <= '0;
      cc_q  <= '0;
      acc_q <= '0;
      dc_q  <= '0;
      err_q <= 1'b0;
      for (int k = 0; k < NumFields; k++) begin
        fv_q[k] <= '0;
      end
    end else if (cmd_i.load_out) begin
      err_q <= 1'b0;
      for (int k = 0; k < NumFields; k++) begin
        fv_q[k] <= '0;
      end
    end else if (cmd_i.parse) begin
      err_q <= err1;
      for (int k = 0; k < NumFields; k++) begin
        fv_q[k] <= fv_d[k];
      end
      if (last_i) begin
        fi_q  <= '0;
        cc_q  <= '0;
        acc_q <= '0;
        dc_q  <= '0;
      end else begin
        fi_q  <= fi2;
        cc_q  <= take ? cc_q + CntW'(1) : cc_q;
        acc_q <= acc1;
        dc_q  <= dc1;
      end
    end
  end

  // Calendar terms
  logic                  early;
  logic [FieldW-1:0]     y_d;
  logic [DaysW-1:0]      doy_d;
  logic [QuartW-1:0]     quart;
  logic [RecipPW-1:0]    recip_p;
  logic [DaysW-1:0]      days_d;
  logic                  fmt_err;

  always_comb begin
    early   = (fv_q[FldMonth] <= FieldW'(2));
    y_d     = fv_q[FldYear] + FieldW'(YearBias) - FieldW'(early);
    doy_d   = DaysW'(days_before_month(fv_q[FldMonth][3:0]))
            + DaysW'(fv_q[FldDay]) - DaysW'(1);
    quart   = y_q[FieldW-1:2];
    recip_p = RecipPW'(quart) * RecipPW'(Recip25);
    days_d  = DaysW'(DaysW'(y_q) * DaysW'(DaysPerYear)) + DaysW'(quart)
            - DaysW'(c100_q) + DaysW'(c100_q[Cent100W-1:2]) + doy_q
            - DaysW'(DaysOffset);
    fmt_err = err_q || (fv_q[FldMonth] == '0) || (fv_q[FldMonth] > FieldW'(12));
  end

  // Shared multiplier: one term of the millisecond sum per step
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] mul_p;

  always_comb begin
    unique case (cmd_i.term)
      TERM_DAYS: begin
        mul_a = $signed({days_q[DaysW-1], days_q});
        mul_b = $signed({1'b0, MsPerDay});
      end
      TERM_HOUR: begin
        mul_a = $signed(MulAW'(fv_q[FldHour]));
        mul_b = $signed({1'b0, MsPerHour});
      end
      TERM_MIN: begin
        mul_a = $signed(MulAW'(fv_q[FldMinute]));
        mul_b = $signed({1'b0, MsPerMin});
      end
      TERM_SEC: begin
        mul_a = $signed(MulAW'(fv_q[FldSecond]));
        mul_b = $signed({1'b0, MsPerSec});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // Arithmetic steps
  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      y_q   <= y_d;
      doy_q <= doy_d;
    end
    if (cmd_i.div) begin
      c100_q <= recip_p[RecipPW-1:Recip25Shift];
    end
    if (cmd_i.days) begin
      days_q <= days_d;
      sum_q  <= EpochW'(fv_q[FldMilli]);
    end
    if (cmd_i.mac) begin
      sum_q <= sum_q + EpochW'(mul_p);
    end
    if (cmd_i.load_out) begin
      out_epoch_q <= fmt_err ? '0 : sum_q;
      out_err_q   <= fmt_err;
    end
  end

  assign epoch_o = out_epoch_q;
  assign err_o   = out_err_q;

`ifndef SYNTHESIS
  a_cc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cc_q <= MaxCnt)
    else $error("character count beyond limit");

  a_dc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dc_q <= DigitCntW'(MaxDigits))
    else $error("digit count beyond four");

  // An erroneous timestamp is reported with a zero count
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.load_out) && out_err_q |-> (out_epoch_q == '0))
    else $error("format error with non-zero result");
`endif

endmodule

FILE: rtl/timestamp_text_to_epoch_ms_top.sv
// Characters are taken one beat per cycle while a timestamp is being parsed.
// After the final character the result is built in these steps: prepare,
// century count, day number, four multiply-accumulate steps on one shared
// multiplier, then the output register; no input is taken in that time.
// Reset (rst_ni, asynchronous, active low) clears all parse state and fields.
// ----------------------------------------------------------------------------
// timestamp_text_to_epoch_ms_top
// Parses "YYYY-MM-DD HH:MM:SS.mmm" text and returns signed milliseconds since
// 1970-01-01 in the proleptic Gregorian calendar, with a format error flag.
// ----------------------------------------------------------------------------
module timestamp_text_to_epoch_ms_top #(
  parameter int unsigned MaxChars = tsepoch_pkg::DefaultMaxChars
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
  input  logic        s_axis_tlast,   // last_char
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [52:0] epoch_ms, [55:53] zero
  output logic        m_axis_tuser    // [0] format_error
);
  import tsepoch_pkg::*;

  cmd_t              cmd;
  logic [EpochW-1:0] epoch;
  logic              fmt_err;

  tsepoch_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  tsepoch_dpath #(
    .MaxChars (MaxChars)
  ) u_dpath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .char_i  (s_axis_tdata),
    .last_i  (s_axis_tlast),
    .epoch_o (epoch),
    .err_o   (fmt_err)
  );

  assign m_axis_tdata = {3'b000, epoch};
  assign m_axis_tuser = fmt_err;

endmodule
